// File: hdl/dsw_pkg.sv
// ----------------------------------------------------------------------------
// dsw_pkg
// Shared types and constants for the dice sum way counter.
// ----------------------------------------------------------------------------
`default_nettype none

package dsw_pkg;

  localparam int unsigned FACE_W  = 7;
  localparam int unsigned DICE_W  = 7;
  localparam int unsigned SUM_W   = 11;
  localparam int unsigned COUNT_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [FACE_W-1:0] face_count;
    logic [DICE_W-1:0] dice_count;
    logic [SUM_W-1:0]  target_sum;
  } req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] way_count;
    logic               saturated;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH,
    ST_HOLD
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic start;     // load request, clear counters
    logic direct;    // load result without table work
    logic issue;     // issue one table entry
    logic load_out;  // move pending result to output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_direct;  // incoming request needs no table work
    logic issue_last;  // entry being issued is the final one
    logic final_wr;    // final entry written, result pending
  } stat_t;

endpackage

`default_nettype wire

// File: hdl/dsw_ctrl.sv
// ----------------------------------------------------------------------------
// dsw_ctrl
// Sequencer: accepts a request, steps the table datapath, hands off result.
// ----------------------------------------------------------------------------
`default_nettype none

module dsw_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  input  wire dsw_pkg::stat_t stat_i,
  output dsw_pkg::cmd_t      cmd_o
);

  dsw_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dsw_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      dsw_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (stat_i.req_direct) begin
            cmd_o.direct = 1'b1;
            state_d      = dsw_pkg::ST_HOLD;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = dsw_pkg::ST_RUN;
          end
        end
      end
      dsw_pkg::ST_RUN: begin
        cmd_o.issue = 1'b1;
        if (stat_i.issue_last) begin
          state_d = dsw_pkg::ST_FLUSH;
        end
      end
      dsw_pkg::ST_FLUSH: begin
        if (stat_i.final_wr) begin
          state_d = dsw_pkg::ST_HOLD;
        end
      end
      dsw_pkg::ST_HOLD: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = dsw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dsw_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: hdl/dsw_dpath.sv
// ----------------------------------------------------------------------------
// dsw_dpath
// Two-bank row memory, sliding-window adder and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module dsw_dpath #(
  parameter int unsigned MAX_SUM   = 1024,
  parameter int unsigned MAX_FACES = 64,
  parameter int unsigned MAX_DICE  = 64
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire dsw_pkg::req_t  in_req_i,
  input  wire dsw_pkg::cmd_t  cmd_i,
  output dsw_pkg::stat_t      stat_o,
  output dsw_pkg::res_t       out_res_o
);

  localparam int unsigned SW = $clog2(MAX_SUM + 1);
  localparam int unsigned DW = $clog2(MAX_DICE + 1);
  localparam int unsigned WW = dsw_pkg::COUNT_W + $clog2(MAX_FACES + 1);

  // request and sequencing registers
  logic [dsw_pkg::FACE_W-1:0] faces_q;
  logic [DW-1:0]              dice_q, d_q;
  logic [SW-1:0]              target_q, t_q;
  logic                       bank_q;

  // issue stage decode
  logic          req_bad, req_zero_dice;
  logic          iss_sub, iss_virt, iss_va, iss_vb;
  logic [SW-1:0] addr_a, addr_b;

  // entry stage
  logic          p_valid_q, p_first_q, p_sub_q, p_virt_q, p_va_q, p_vb_q, p_final_q;
  logic [SW-1:0] p_t_q;
  logic          p_bank_q;

  logic [dsw_pkg::COUNT_W-1:0] row_mem [2][MAX_SUM+1];
  logic [dsw_pkg::COUNT_W-1:0] rd_a_q, rd_b_q;

  logic [WW-1:0]               window_q, window_d, a_val, b_val;
  logic [dsw_pkg::COUNT_W-1:0] wr_data;

  dsw_pkg::res_t res_q, out_q;

  assign req_bad = (32'(in_req_i.face_count) > 32'(MAX_FACES)) ||
                   (32'(in_req_i.dice_count) > 32'(MAX_DICE)) ||
                   (32'(in_req_i.target_sum) > 32'(MAX_SUM));
  assign req_zero_dice = (in_req_i.dice_count == '0);

  assign stat_o.req_direct = req_bad || req_zero_dice;
  assign stat_o.issue_last = (t_q == target_q) && (d_q == dice_q);
  assign stat_o.final_wr   = p_valid_q && p_final_q;

  // window drops the entry that falls out once t exceeds the face count
  assign iss_sub  = (32'(t_q) > 32'(faces_q));
  // first die reads the implicit start row: one at sum zero, zero elsewhere
  assign iss_virt = (d_q == DW'(1));
  assign iss_va   = (t_q == SW'(1));
  assign iss_vb   = iss_sub && (32'(t_q) == 32'(faces_q) + 32'd1);
  assign addr_a   = (t_q == '0) ? '0 : t_q - SW'(1);
  assign addr_b   = iss_sub ? SW'(32'(t_q) - 32'(faces_q) - 32'd1) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_q       <= '0;
      d_q       <= '0;
      bank_q    <= 1'b0;
      p_valid_q <= 1'b0;
    end else begin
      p_valid_q <= cmd_i.issue;
      if (cmd_i.start) begin
        t_q    <= '0;
        d_q    <= DW'(1);
        bank_q <= 1'b0;
      end else if (cmd_i.issue) begin
        if (t_q == target_q) begin
          t_q    <= '0;
          d_q    <= d_q + DW'(1);
          bank_q <= ~bank_q;
        end else begin
          t_q <= t_q + SW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      faces_q  <= in_req_i.face_count;
      dice_q   <= DW'(in_req_i.dice_count);
      target_q <= SW'(in_req_i.target_sum);
    end
    p_t_q     <= t_q;
    p_bank_q  <= bank_q;
    p_first_q <= (t_q == '0);
    p_sub_q   <= iss_sub;
    p_virt_q  <= iss_virt;
    p_va_q    <= iss_va;
    p_vb_q    <= iss_vb;
    p_final_q <= stat_o.issue_last;
    // previous row lives in the bank not being written this die
    rd_a_q    <= row_mem[~bank_q][addr_a];
    rd_b_q    <= row_mem[~bank_q][addr_b];
  end

  always_comb begin
    if (p_virt_q) begin
      a_val = WW'(p_va_q);
      b_val = WW'(p_vb_q);
    end else begin
      a_val = WW'(rd_a_q);
      b_val = WW'(rd_b_q);
    end
    if (p_first_q) begin
      window_d = '0;
    end else if (p_sub_q) begin
      window_d = window_q + a_val - b_val;
    end else begin
      window_d = window_q + a_val;
    end
    if (window_d >= WW'(dsw_pkg::COUNT_MAX)) begin
      wr_data = dsw_pkg::COUNT_MAX;
    end else begin
      wr_data = window_d[dsw_pkg::COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_valid_q) begin
      row_mem[p_bank_q][p_t_q] <= wr_data;
      window_q                 <= window_d;
    end
    if (cmd_i.direct) begin
      res_q.saturated <= 1'b0;
      if (!req_bad && (in_req_i.target_sum == '0)) begin
        res_q.way_count <= dsw_pkg::COUNT_W'(1);
      end else begin
        res_q.way_count <= '0;
      end
    end else if (p_valid_q && p_final_q) begin
      res_q.way_count <= wr_data;
      res_q.saturated <= (wr_data == dsw_pkg::COUNT_MAX);
    end
    if (cmd_i.load_out) begin
      out_q <= res_q;
    end
  end

  assign out_res_o = out_q;

endmodule

`default_nettype wire

// File: hdl/dice_sum_way_counter.sv
// ----------------------------------------------------------------------------
// dice_sum_way_counter: counts ordered dice throws reaching a target sum
// Each die fills one row entry per cycle, up to the target sum; zero dice or a
// rejected request loads its result directly without table work.
// The next request is accepted in the cycle after the result is loaded, so
// requests do not overlap; a stalled result holds the sequencer.
// Reset clears the sequencer and output valid; row memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module dice_sum_way_counter #(
  parameter int unsigned MAX_SUM   = 1024,
  parameter int unsigned MAX_FACES = 64,
  parameter int unsigned MAX_DICE  = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire dsw_pkg::req_t in_req_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output dsw_pkg::res_t      out_res_o
);

  dsw_pkg::cmd_t  cmd;
  dsw_pkg::stat_t stat;

  dsw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dsw_dpath #(
    .MAX_SUM   (MAX_SUM),
    .MAX_FACES (MAX_FACES),
    .MAX_DICE  (MAX_DICE)
  ) u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req_i  (in_req_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .out_res_o (out_res_o)
  );

endmodule

`default_nettype wire
